// ===== sv/percent_escape_decoder_assert.svh =====
// Assertion macros for the percent escape decoder.
// Used by the top level; relies on clk and arst_n being in scope.
`ifndef PERCENT_ESCAPE_DECODER_ASSERT_SVH
`define PERCENT_ESCAPE_DECODER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PCTD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pctd assertion failed (same cycle)");

// Next-cycle implication, checked out of reset.
`define PCTD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pctd assertion failed (next cycle)");

`endif

// ===== sv/pctd_pkg.sv =====
// Shared types, character codes and helpers for the percent escape decoder.
// No dependencies; used by pctd_step, pctd_out_fifo and the top level.
package pctd_pkg;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_COLON   = 8'h3A;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;

	localparam logic [4:0] HEX_NONE = 5'h10;

	// Input transaction kind carried on the slave tuser bit.
	localparam logic CMD_DATA = 1'b0;
	localparam logic CMD_END  = 1'b1;

	typedef enum logic [4:0] {
		PH_PLAIN  = 5'b00001,
		PH_BSLASH = 5'b00010,
		PH_PCT1   = 5'b00100,
		PH_PCT2   = 5'b01000,
		PH_DROP   = 5'b10000
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_BAD_HEX = 2'd1,
		ST_ZERO    = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       is_byte;
		status_t    status;
		logic       last;
	} result_t;

	// Up to two results produced by one input transaction.
	typedef struct packed {
		logic [1:0] num;
		result_t    r0;
		result_t    r1;
	} push_t;

	// Digit value in the low four bits; HEX_NONE when not a hex digit.
	function automatic logic [4:0] hex_value(logic [7:0] c);
		logic [4:0] v;
		v = HEX_NONE;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = {1'b0, c[3:0]};
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			v = {1'b0, c[3:0] + 4'd9};
		end
		return v;
	endfunction

	function automatic result_t byte_result(logic [7:0] b, logic last);
		result_t r;
		r.out_byte = b;
		r.is_byte  = 1'b1;
		r.status   = ST_OK;
		r.last     = last;
		return r;
	endfunction

	function automatic result_t status_result(status_t st);
		result_t r;
		r.out_byte = 8'h00;
		r.is_byte  = 1'b0;
		r.status   = st;
		r.last     = 1'b1;
		return r;
	endfunction

endpackage

// ===== sv/pctd_step.sv =====
// Escape state machine next-state and result logic for one transaction.
// Depends on pctd_pkg; purely combinational, state is held by the top level.
module pctd_step import pctd_pkg::*; (
	input  phase_t     phase,
	input  logic [3:0] nibble,
	input  status_t    err,
	input  logic       colon_en,
	input  logic       cmd,
	input  logic [7:0] data_byte,
	output push_t      push,
	output phase_t     phase_d,
	output logic [3:0] nibble_d,
	output status_t    err_d
);

	always_comb begin
		logic [4:0] h;
		logic [7:0] v;
		status_t    st;
		h        = hex_value(data_byte);
		v        = {nibble, h[3:0]};
		st       = err;
		push     = '0;
		phase_d  = phase;
		nibble_d = nibble;
		err_d    = err;
		if (cmd == CMD_END) begin
			// End marker: flush a held backslash, report status, clear state.
			if (phase == PH_PCT1 || phase == PH_PCT2) begin
				st = ST_BAD_HEX;
			end
			if (phase == PH_BSLASH) begin
				push.num = 2'd2;
				push.r0  = byte_result(CH_BSLASH, 1'b0);
				push.r1  = status_result(st);
			end else begin
				push.num = 2'd1;
				push.r0  = status_result(st);
			end
			phase_d  = PH_PLAIN;
			nibble_d = 4'h0;
			err_d    = ST_OK;
		end else begin
			unique case (phase)
				PH_BSLASH: begin
					phase_d = PH_PLAIN;
					if (data_byte == CH_COLON) begin
						push.num = 2'd1;
						push.r0  = byte_result(CH_COLON, 1'b1);
					end else if (data_byte == CH_PERCENT) begin
						push.num = 2'd1;
						push.r0  = byte_result(CH_BSLASH, 1'b1);
						phase_d  = PH_PCT1;
					end else if (data_byte == CH_BSLASH && colon_en) begin
						// Emit the first backslash, hold the second.
						push.num = 2'd1;
						push.r0  = byte_result(CH_BSLASH, 1'b1);
						phase_d  = PH_BSLASH;
					end else begin
						push.num = 2'd2;
						push.r0  = byte_result(CH_BSLASH, 1'b0);
						push.r1  = byte_result(data_byte, 1'b1);
					end
				end
				PH_PCT1: begin
					if (h[4]) begin
						err_d    = ST_BAD_HEX;
						phase_d  = PH_DROP;
						nibble_d = 4'h0;
					end else begin
						nibble_d = h[3:0];
						phase_d  = PH_PCT2;
					end
				end
				PH_PCT2: begin
					nibble_d = 4'h0;
					if (h[4]) begin
						err_d   = ST_BAD_HEX;
						phase_d = PH_DROP;
					end else if (v == 8'h00) begin
						err_d   = ST_ZERO;
						phase_d = PH_DROP;
					end else begin
						push.num = 2'd1;
						push.r0  = byte_result(v, 1'b1);
						phase_d  = PH_PLAIN;
					end
				end
				PH_DROP: begin
					phase_d = PH_DROP;
				end
				default: begin
					phase_d = PH_PLAIN;
					if (data_byte == CH_PERCENT) begin
						phase_d = PH_PCT1;
					end else if (data_byte == CH_BSLASH && colon_en) begin
						phase_d = PH_BSLASH;
					end else begin
						push.num = 2'd1;
						push.r0  = byte_result(data_byte, 1'b1);
					end
				end
			endcase
		end
	end

endmodule

// ===== sv/pctd_out_fifo.sv =====
// Result queue: takes up to two results per cycle, gives out one per cycle when pop is high.
// Depends on pctd_pkg for the result and push types.
module pctd_out_fifo import pctd_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  push_t   push,
	input  logic    pop,
	output logic    room2,
	output logic    out_valid,
	output result_t dout
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW:0] LIMIT = (CW + 1)'(DEPTH - 2);

	result_t         mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic [PW-1:0]   wr_ptr_1;

	function automatic logic [PW-1:0] inc(logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign wr_ptr_1  = inc(wr_ptr_q);
	assign out_valid = (count_q != '0);
	assign dout      = mem_q[rd_ptr_q];
	// Room for two more results once this cycle's pop is taken into account.
	assign room2     = ({1'b0, count_q} <= LIMIT + {{CW{1'b0}}, pop});

	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.num == 2'd2) begin
			mem_q[wr_ptr_1] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.num == 2'd1) begin
				wr_ptr_q <= wr_ptr_1;
			end else if (push.num == 2'd2) begin
				wr_ptr_q <= inc(wr_ptr_1);
			end
			if (pop) begin
				rd_ptr_q <= inc(rd_ptr_q);
			end
			count_q <= count_q + CW'(push.num) - CW'(pop);
		end
	end

endmodule

// ===== sv/percent_escape_decoder.sv =====
// Percent escape decoder. Takes one string byte (or end marker) per cycle on
// the slave stream while its input register is empty or the result queue has
// room for two results, and gives decoded bytes and one end status per string
// on the master stream. Input is registered, decoded once the queue has room
// for two results and pushed into a FIFO_DEPTH-entry result queue; sustained
// rate is one input per cycle while each item yields at most one result and
// the master stream does not stall; an item yielding two results (held
// backslash plus following byte or end status) adds a result to drain, and
// the queue drain of one result per cycle sets the long-term rate.
// Depends on pctd_pkg, pctd_step, pctd_out_fifo and the assertion header.
`include "percent_escape_decoder_assert.svh"

module percent_escape_decoder import pctd_pkg::*; #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,       // colon_escape_enable
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tuser,   // [0] cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [9:8] status, rest zero
	output logic        m_axis_tuser,   // [0] is_byte
	output logic        m_axis_tlast
);

	logic       colon_en_q;
	logic       v_s1;
	logic       cmd_s1;
	logic [7:0] byte_s1;
	phase_t     phase_q;
	logic [3:0] nibble_q;
	status_t    err_q;

	phase_t     phase_d;
	logic [3:0] nibble_d;
	status_t    err_d;
	push_t      step_push;
	push_t      fifo_push;
	logic       room2;
	logic       proc;
	logic       pop;
	logic       in_accept;
	result_t    dout;

	assign cfg_ready     = 1'b1;
	assign proc          = v_s1 && room2;
	assign s_axis_tready = !v_s1 || room2;
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign pop           = m_axis_tvalid && m_axis_tready;

	always_comb begin
		fifo_push = step_push;
		if (!proc) begin
			fifo_push.num = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colon_en_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			colon_en_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_accept) begin
			v_s1 <= 1'b1;
		end else if (proc) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_s1  <= s_axis_tuser;
			byte_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_PLAIN;
			nibble_q <= 4'h0;
			err_q    <= ST_OK;
		end else if (proc) begin
			phase_q  <= phase_d;
			nibble_q <= nibble_d;
			err_q    <= err_d;
		end
	end

	pctd_step u_step (
		.phase     (phase_q),
		.nibble    (nibble_q),
		.err       (err_q),
		.colon_en  (colon_en_q),
		.cmd       (cmd_s1),
		.data_byte (byte_s1),
		.push      (step_push),
		.phase_d   (phase_d),
		.nibble_d  (nibble_d),
		.err_d     (err_d)
	);

	pctd_out_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fifo_push),
		.pop       (pop),
		.room2     (room2),
		.out_valid (m_axis_tvalid),
		.dout      (dout)
	);

	assign m_axis_tdata = {6'b0, dout.status, dout.out_byte};
	assign m_axis_tuser = dout.is_byte;
	assign m_axis_tlast = dout.last;

	`PCTD_ASSERT_NEXT(a_end_clears, proc && cmd_s1, phase_q == PH_PLAIN && err_q == ST_OK)
	`PCTD_ASSERT_NOW(a_drop_has_err, phase_q == PH_DROP, err_q != ST_OK)
	`PCTD_ASSERT_NEXT(a_s1_holds, v_s1 && !proc, v_s1 && $stable(byte_s1) && $stable(cmd_s1))
	`PCTD_ASSERT_NOW(a_status_byte, m_axis_tvalid && m_axis_tuser, m_axis_tdata[9:8] == 2'd0)

endmodule
